@@ src/pptd_pkg.sv @@
package pptd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_POKE  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_PUSH    = 3'd1;
  localparam logic [2:0] OP_DEFAULT = 3'd2;
  localparam logic [2:0] OP_REVERSE = 3'd3;
  localparam logic [2:0] OP_ALL     = 3'd4;

  localparam logic [1:0] PHASE_POKE    = 2'd0;
  localparam logic [1:0] PHASE_RELEASE = 2'd1;
  localparam logic [1:0] PHASE_PUSHING = 2'd2;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_REPLIED = 2'd1;
  localparam logic [1:0] STAT_NO_PORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PUSH_TICKS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_ENABLE = 2'd3;

  typedef enum logic [2:0] {
    PH_POKE    = 3'b001,
    PH_RELEASE = 3'b010,
    PH_PUSHING = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] port;
    logic       line_level;
  } in_req_t;

  typedef struct packed {
    logic [2:0] line_op;
    logic [2:0] line_port;
    logic       note_source;
    logic       note_done;
    logic       note_next;
    logic [1:0] poke_status;
    logic [2:0] found_port;
    logic       busy_res;
    logic [3:0] active_port;
    logic [1:0] phase;
  } out_res_t;

endpackage

@@ src/pptd_ctrl.sv @@
module pptd_ctrl #(
  parameter int PORT_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr,
  input  logic [pptd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pptd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_accept,
  input  pptd_pkg::in_req_t                 req,
  output pptd_pkg::out_res_t                res
);
  import pptd_pkg::*;

  logic [7:0]            push_ticks_r;
  logic [7:0]            sample_ticks_r;
  logic [15:0]           release_timeout_r;
  logic                  watchdog_enable_r;

  phase_t                phase_r, phase_nxt;
  logic [PORT_COUNT-1:0] map_r, map_nxt;
  logic [3:0]            active_r, active_nxt;
  logic                  keep_r, keep_nxt;
  logic [2:0]            poke_port_r, poke_port_nxt;
  logic [7:0]            poke_ticks_r, poke_ticks_nxt;
  logic [15:0]           rel_ticks_r, rel_ticks_nxt;

  logic                  free_found;
  logic [2:0]            free_idx;
  logic                  port_ok;
  logic [7:0]            push_eff;
  logic [7:0]            ticks_inc;
  logic [15:0]           rel_inc;
  logic                  start_next;
  logic                  clear_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_ticks_r      <= 8'd2;
      sample_ticks_r    <= 8'd3;
      release_timeout_r <= 16'd500;
      watchdog_enable_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_PUSH_TICKS:      push_ticks_r      <= cfg_data[7:0];
        REG_SAMPLE_TICKS:    sample_ticks_r    <= cfg_data[7:0];
        REG_RELEASE_TIMEOUT: release_timeout_r <= cfg_data;
        REG_WATCHDOG_ENABLE: watchdog_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = 3'd0;
    for (int i = PORT_COUNT - 1; i >= 0; i--) begin
      if (!map_r[i]) begin
        free_found = 1'b1;
        free_idx   = 3'(i);
      end
    end
  end

  assign port_ok   = ({1'b0, req.port} < 4'(PORT_COUNT));
  assign push_eff  = (push_ticks_r == 8'd0) ? 8'd1 : push_ticks_r;
  assign ticks_inc = (poke_ticks_r == 8'hFF) ? 8'hFF : poke_ticks_r + 8'd1;
  assign rel_inc   = (rel_ticks_r == 16'hFFFF) ? 16'hFFFF : rel_ticks_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    map_nxt       = map_r;
    active_nxt    = active_r;
    keep_nxt      = keep_r;
    poke_port_nxt = poke_port_r;
    poke_ticks_nxt = poke_ticks_r;
    rel_ticks_nxt = rel_ticks_r;
    start_next    = 1'b0;
    clear_all     = 1'b0;
    res           = '0;

    case (req.cmd)
      CMD_RESET: begin
        clear_all   = 1'b1;
        res.line_op = OP_ALL;
      end
      CMD_EDGE: begin
        if (phase_r == PH_RELEASE) begin
          phase_nxt     = PH_POKE;
          keep_nxt      = 1'b0;
          rel_ticks_nxt = 16'd0;
          if (&map_r) begin
            res.note_done = 1'b1;
            clear_all     = 1'b1;
            res.line_op   = OP_ALL;
          end
          res.note_next = 1'b1;
        end else if (phase_r == PH_POKE && port_ok) begin
          res.line_op   = OP_PUSH;
          res.line_port = req.port;
          for (int i = 0; i < PORT_COUNT; i++) begin
            if (req.port == 3'(i)) begin
              map_nxt[i] = 1'b1;
            end
          end
          active_nxt      = {1'b0, req.port};
          res.note_source = 1'b1;
        end
      end
      CMD_POKE: begin
        if (phase_r != PH_PUSHING) begin
          start_next = 1'b1;
        end
      end
      default: begin
        if (phase_r == PH_PUSHING) begin
          poke_ticks_nxt = ticks_inc;
          if (poke_ticks_r >= push_eff) begin
            if (ticks_inc >= sample_ticks_r) begin
              if (req.line_level) begin
                res.line_op     = OP_REVERSE;
                res.line_port   = poke_port_r;
                phase_nxt       = PH_RELEASE;
                rel_ticks_nxt   = 16'd0;
                active_nxt      = {1'b0, poke_port_r};
                keep_nxt        = 1'b1;
                res.poke_status = STAT_REPLIED;
                res.found_port  = poke_port_r;
              end else begin
                start_next = 1'b1;
              end
            end
          end else if (ticks_inc >= push_eff) begin
            res.line_op   = OP_DEFAULT;
            res.line_port = poke_port_r;
          end
        end else if (phase_r == PH_RELEASE) begin
          rel_ticks_nxt = rel_inc;
          if (watchdog_enable_r && (rel_inc > release_timeout_r)) begin
            res.note_done = 1'b1;
            res.note_next = 1'b1;
            clear_all     = 1'b1;
            res.line_op   = OP_ALL;
          end
        end
      end
    endcase

    if (start_next) begin
      if (free_found) begin
        phase_nxt          = PH_PUSHING;
        for (int i = 0; i < PORT_COUNT; i++) begin
          if (free_idx == 3'(i)) begin
            map_nxt[i] = 1'b1;
          end
        end
        poke_port_nxt  = free_idx;
        poke_ticks_nxt = 8'd0;
        res.line_op    = OP_PUSH;
        res.line_port  = free_idx;
      end else begin
        res.note_done   = 1'b1;
        res.poke_status = STAT_NO_PORT;
        clear_all       = 1'b1;
        res.line_op     = OP_ALL;
      end
    end

    if (clear_all) begin
      phase_nxt      = PH_POKE;
      map_nxt        = '0;
      active_nxt     = 4'(PORT_COUNT);
      keep_nxt       = 1'b0;
      poke_port_nxt  = 3'd0;
      poke_ticks_nxt = 8'd0;
      rel_ticks_nxt  = 16'd0;
    end

    res.busy_res    = keep_nxt;
    res.active_port = active_nxt;
    case (phase_nxt)
      PH_POKE:    res.phase = PHASE_POKE;
      PH_RELEASE: res.phase = PHASE_RELEASE;
      PH_PUSHING: res.phase = PHASE_PUSHING;
      default:    res.phase = PHASE_POKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_POKE;
      map_r        <= '0;
      active_r     <= 4'(PORT_COUNT);
      keep_r       <= 1'b0;
      poke_port_r  <= 3'd0;
      poke_ticks_r <= 8'd0;
      rel_ticks_r  <= 16'd0;
    end else if (req_accept) begin
      phase_r      <= phase_nxt;
      map_r        <= map_nxt;
      active_r     <= active_nxt;
      keep_r       <= keep_nxt;
      poke_port_r  <= poke_port_nxt;
      poke_ticks_r <= poke_ticks_nxt;
      rel_ticks_r  <= rel_ticks_nxt;
    end
  end

endmodule

@@ src/pptd_obuf.sv @@
module pptd_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pptd_pkg::out_res_t push_res,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output pptd_pkg::out_res_t out_res
);
  import pptd_pkg::*;

  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  out_res_t main_res_r, main_res_nxt;
  out_res_t skid_res_r, skid_res_nxt;
  logic     pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_res_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_res_nxt   = main_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_res_nxt   = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_res_r <= main_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

@@ src/ptp_port_topology_detector_top.sv @@
// Topology-detection sequencer for point-to-point poke lines. Each accepted request
// (reset, line edge, poke next port, or millisecond tick with the sampled line level)
// updates the sequencer state in the cycle it is taken and produces exactly one result,
// which is registered in the output buffer. A request can be accepted every clock cycle
// while in_stall is low; a two-entry output register with skid stage lets a new request
// enter while an earlier result waits. in_stall rises only when both output entries are
// occupied. Configuration writes are always ready and should be issued only while no
// result is pending.
module ptp_port_topology_detector_top #(
  parameter int PORT_COUNT = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pptd_pkg::in_req_t               in_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pptd_pkg::out_res_t              out_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pptd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pptd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pptd_pkg::*;

  logic     accept;
  logic     full;
  out_res_t step_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  pptd_ctrl #(
    .PORT_COUNT(PORT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_accept(accept),
    .req       (in_req),
    .res       (step_res)
  );

  pptd_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_res (step_res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

endmodule

@@ src/pptd_checker.sv @@
module pptd_checker #(
  parameter int PORT_COUNT = 4
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pptd_pkg::out_res_t out_res
);
  import pptd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("Stalled result changed or was dropped.");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled with no result waiting.");

  a_all_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.line_op == OP_ALL |->
      out_res.active_port == 4'(PORT_COUNT) && out_res.phase == PHASE_POKE &&
      !out_res.busy_res)
    else $error("All-lines-default result without cleared state.");

  a_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.note_source |->
      out_res.line_op == OP_PUSH && out_res.phase == PHASE_POKE &&
      out_res.active_port == {1'b0, out_res.line_port})
    else $error("Source notification with inconsistent line command.");

  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.poke_status == STAT_REPLIED |->
      out_res.line_op == OP_REVERSE && out_res.busy_res &&
      out_res.phase == PHASE_RELEASE)
    else $error("Reply result without reversed line and release wait.");

endmodule

bind ptp_port_topology_detector_top pptd_checker #(
  .PORT_COUNT(PORT_COUNT)
) u_pptd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_res  (out_res)
);
